/* design/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while in reset.
`define DLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while in reset.
`define DLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define DLR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dlr_pkg.sv */
// Package: constants, types and register codes of the daylight LED ramp.
package dlr_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LEVELS   = 4;
  localparam int DIV_BITS = 16;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] C1_X3    = 17'd82575;   // 3 * 0.42 in Q1.16
  localparam logic [16:0] C2_X3    = 17'd114033;  // 3 * 0.58 in Q1.16
  localparam logic [6:0]  LEVEL_MAX = 7'd100;

  typedef enum logic [1:0] {
    PH_OFF     = 2'd0,
    PH_SUNRISE = 2'd1,
    PH_PEAK    = 2'd2,
    PH_SUNSET  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    REG_ON_TIME      = 4'd0,
    REG_PEAK_START   = 4'd1,
    REG_PEAK_END     = 4'd2,
    REG_OFF_TIME     = 4'd3,
    REG_PEAK_LEVEL_0 = 4'd4,
    REG_PEAK_LEVEL_1 = 4'd5,
    REG_PEAK_LEVEL_2 = 4'd6,
    REG_PEAK_LEVEL_3 = 4'd7
  } reg_idx_t;

endpackage

/* design/daylight_led_ramp.sv */
// Daylight LED ramp: time of day in, one brightness level per channel out.
//
// Input channel (in_*): one transaction carries hour and minute. Result channel
// (out_*): for every input, dlr_pkg::CHANNELS transactions in channel order,
// tlast on the final channel. Configuration channel (cfg_*): always ready,
// writes register index cfg_index with cfg_data; indexes above 7 are dropped.
// Write configuration only while no input is in flight.
// Pipeline: minute-of-day, phase select, a 16-stage restoring divider (one
// quotient bit per stage), three Bezier multiply stages and a sum stage, a
// channel serializer and an output register.
// The serializer emits one level per cycle from one multiplier while out_tready
// allows it, and takes the next input only after its final channel.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// schedule 480/600/1080/1200 with all peak levels at 100.
// With out_tready low, the output register holds its transaction and the
// pipeline stops once serializer and sum stage fill; nothing is lost or repeated.
module daylight_led_ramp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] hour, [10:5] minute, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] level, [7] zero
  output logic [3:0]  out_tuser,  // [1:0] channel, [3:2] phase
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int NDIV = dlr_pkg::DIV_BITS;

  // configuration
  logic [10:0] on_time_r, peak_start_r, peak_end_r, off_time_r;
  logic [6:0]  peak_level_r [dlr_pkg::LEVELS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r    <= 11'd480;
      peak_start_r <= 11'd600;
      peak_end_r   <= 11'd1080;
      off_time_r   <= 11'd1200;
      for (int i = 0; i < dlr_pkg::LEVELS; i++) peak_level_r[i] <= 7'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dlr_pkg::REG_ON_TIME:      on_time_r       <= cfg_data;
        dlr_pkg::REG_PEAK_START:   peak_start_r    <= cfg_data;
        dlr_pkg::REG_PEAK_END:     peak_end_r      <= cfg_data;
        dlr_pkg::REG_OFF_TIME:     off_time_r      <= cfg_data;
        dlr_pkg::REG_PEAK_LEVEL_0: peak_level_r[0] <= cfg_data[6:0];
        dlr_pkg::REG_PEAK_LEVEL_1: peak_level_r[1] <= cfg_data[6:0];
        dlr_pkg::REG_PEAK_LEVEL_2: peak_level_r[2] <= cfg_data[6:0];
        dlr_pkg::REG_PEAK_LEVEL_3: peak_level_r[3] <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv, ser_take, out_load, ser_emit, ser_last;
  logic b4_v_r;

  assign adv       = !b4_v_r || ser_take;
  assign in_tready = adv;

  // stage 1: minute of day
  logic        s1_v_r;
  logic [10:0] s1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) s1_m_r <= 11'(11'(in_tdata[4:0]) * 11'd60) + 11'(in_tdata[10:5]);
  end

  // stage 2: phase, elapsed and duration
  logic              s2_v_r;
  dlr_pkg::phase_t   s2_ph_r, s2_ph_nxt;
  logic [10:0]       s2_e_r, s2_e_nxt, s2_d_r, s2_d_nxt;

  always_comb begin
    s2_e_nxt = 11'd0;
    s2_d_nxt = 11'd1;
    if (s1_m_r < on_time_r || s1_m_r >= off_time_r) begin
      s2_ph_nxt = dlr_pkg::PH_OFF;
    end else if (s1_m_r < peak_start_r) begin
      s2_ph_nxt = dlr_pkg::PH_SUNRISE;
      s2_e_nxt  = s1_m_r - on_time_r;
      s2_d_nxt  = peak_start_r - on_time_r;
    end else if (s1_m_r < peak_end_r) begin
      s2_ph_nxt = dlr_pkg::PH_PEAK;
    end else begin
      s2_ph_nxt = dlr_pkg::PH_SUNSET;
      s2_e_nxt  = s1_m_r - peak_end_r;
      s2_d_nxt  = off_time_r - peak_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ph_r <= s2_ph_nxt;
      s2_e_r  <= s2_e_nxt;
      s2_d_r  <= s2_d_nxt;
    end
  end

  // divider: one quotient bit per stage, remainder stays below the divisor
  logic            dv_v_r  [NDIV];
  dlr_pkg::phase_t dv_ph_r [NDIV];
  logic [10:0]     dv_r_r  [NDIV];
  logic [10:0]     dv_d_r  [NDIV];
  logic [15:0]     dv_q_r  [NDIV];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic            v_in;
    dlr_pkg::phase_t ph_in;
    logic [10:0]     r_in, d_in;
    logic [15:0]     q_in;
    logic [11:0]     r2;
    logic            bit_q;

    if (k == 0) begin : g_first
      assign v_in  = s2_v_r;
      assign ph_in = s2_ph_r;
      assign r_in  = s2_e_r;
      assign d_in  = s2_d_r;
      assign q_in  = 16'd0;
    end else begin : g_next
      assign v_in  = dv_v_r[k-1];
      assign ph_in = dv_ph_r[k-1];
      assign r_in  = dv_r_r[k-1];
      assign d_in  = dv_d_r[k-1];
      assign q_in  = dv_q_r[k-1];
    end

    assign r2    = {r_in, 1'b0};
    assign bit_q = (r2 >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k] <= 1'b0;
      else if (adv) dv_v_r[k] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ph_r[k] <= ph_in;
        dv_d_r[k]  <= d_in;
        dv_r_r[k]  <= bit_q ? 11'(r2 - {1'b0, d_in}) : r2[10:0];
        dv_q_r[k]  <= {q_in[14:0], bit_q};
      end
    end
  end

  // Bezier stage 1: squares
  logic            b1_v_r;
  dlr_pkg::phase_t b1_ph_r;
  logic [15:0]     b1_p_r, b1_p2_r;
  logic [16:0]     b1_q_r, b1_q2_r;
  logic [15:0]     dv_p;
  logic [16:0]     dv_qq;
  logic [33:0]     pp_full, qq_full;

  assign dv_p    = dv_q_r[NDIV-1];
  assign dv_qq   = dlr_pkg::ONE_Q16 - 17'(dv_p);
  assign pp_full = 34'(dv_p) * 34'(dv_p);
  assign qq_full = 34'(dv_qq) * 34'(dv_qq);

  always_ff @(posedge clk) begin
    if (!rst_n) b1_v_r <= 1'b0;
    else if (adv) b1_v_r <= dv_v_r[NDIV-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_ph_r <= dv_ph_r[NDIV-1];
      b1_p_r  <= dv_p;
      b1_q_r  <= dv_qq;
      b1_p2_r <= pp_full[31:16];
      b1_q2_r <= qq_full[32:16];
    end
  end

  // Bezier stage 2: cubic terms
  logic            b2_v_r;
  dlr_pkg::phase_t b2_ph_r;
  logic [15:0]     b2_p3_r, b2_a_r, b2_b_r;
  logic [33:0]     p3_full, a_full, b_full;

  assign p3_full = 34'(b1_p2_r) * 34'(b1_p_r);
  assign a_full  = 34'(b1_q2_r) * 34'(b1_p_r);
  assign b_full  = 34'(b1_q_r) * 34'(b1_p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) b2_v_r <= 1'b0;
    else if (adv) b2_v_r <= b1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b2_ph_r <= b1_ph_r;
      b2_p3_r <= p3_full[31:16];
      b2_a_r  <= a_full[31:16];
      b2_b_r  <= b_full[31:16];
    end
  end

  // Bezier stage 3: weight by control points
  logic            b3_v_r;
  dlr_pkg::phase_t b3_ph_r;
  logic [15:0]     b3_p3_r;
  logic [16:0]     b3_ta_r, b3_tb_r;
  logic [32:0]     ta_full, tb_full;

  assign ta_full = 33'(b2_a_r) * 33'(dlr_pkg::C1_X3);
  assign tb_full = 33'(b2_b_r) * 33'(dlr_pkg::C2_X3);

  always_ff @(posedge clk) begin
    if (!rst_n) b3_v_r <= 1'b0;
    else if (adv) b3_v_r <= b2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b3_ph_r <= b2_ph_r;
      b3_p3_r <= b2_p3_r;
      b3_ta_r <= ta_full[32:16];
      b3_tb_r <= tb_full[32:16];
    end
  end

  // Bezier stage 4: sum, cap, and pick the level factor for the phase
  dlr_pkg::phase_t b4_ph_r;
  logic [16:0]     b4_f_r, b4_f_nxt;
  logic [18:0]     bez_sum;
  logic [16:0]     bez;

  assign bez_sum = 19'(b3_ta_r) + 19'(b3_tb_r) + 19'(b3_p3_r);
  assign bez     = (bez_sum > 19'(dlr_pkg::ONE_Q16)) ? dlr_pkg::ONE_Q16 : bez_sum[16:0];

  always_comb begin
    case (b3_ph_r)
      dlr_pkg::PH_SUNRISE: b4_f_nxt = bez;
      dlr_pkg::PH_PEAK:    b4_f_nxt = dlr_pkg::ONE_Q16;
      dlr_pkg::PH_SUNSET:  b4_f_nxt = dlr_pkg::ONE_Q16 - bez;
      default:             b4_f_nxt = 17'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b4_v_r <= 1'b0;
    else if (adv) b4_v_r <= b3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b4_ph_r <= b3_ph_r;
      b4_f_r  <= b4_f_nxt;
    end
  end

  // channel serializer
  logic                     ser_v_r;
  dlr_pkg::phase_t          ser_ph_r;
  logic [16:0]              ser_f_r;
  logic [dlr_pkg::CH_W-1:0] ch_r;
  logic [6:0]               pk;
  logic [23:0]              lvl_full;
  logic [6:0]               lvl;

  assign ser_last = (ch_r == dlr_pkg::CH_W'(dlr_pkg::CHANNELS - 1));
  assign out_load = !out_tvalid || out_tready;
  assign ser_emit = ser_v_r && out_load;
  assign ser_take = !ser_v_r || (ser_last && out_load);

  assign pk       = (peak_level_r[2'(ch_r)] > dlr_pkg::LEVEL_MAX) ? dlr_pkg::LEVEL_MAX
                                                               : peak_level_r[2'(ch_r)];
  assign lvl_full = 24'(pk) * 24'(ser_f_r);
  assign lvl      = (lvl_full[23:16] > 8'(dlr_pkg::LEVEL_MAX)) ? dlr_pkg::LEVEL_MAX
                                                               : lvl_full[22:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      ch_r    <= '0;
    end else if (ser_take) begin
      ser_v_r <= b4_v_r;
      ch_r    <= '0;
    end else if (ser_emit) begin
      ch_r    <= ch_r + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_ph_r <= b4_ph_r;
      ser_f_r  <= b4_f_r;
    end
  end

  // output register
  logic            out_v_r;
  logic [1:0]      out_ch_r;
  dlr_pkg::phase_t out_ph_r;
  logic [6:0]      out_lvl_r;
  logic            out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_load) out_v_r <= ser_v_r;
  end
  always_ff @(posedge clk) begin
    if (ser_emit) begin
      out_ch_r   <= 2'(ch_r);
      out_ph_r   <= ser_ph_r;
      out_lvl_r  <= lvl;
      out_last_r <= ser_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_lvl_r};
  assign out_tuser  = {out_ph_r, out_ch_r};
  assign out_tlast  = out_last_r;

endmodule

/* design/dlr_checker.sv */
// Port-level checker for the daylight LED ramp, bound to the top level.
`include "assert_macros.svh"

module dlr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);

  logic stalled;
  logic last_ch;

  assign stalled = out_tvalid && !out_tready;
  assign last_ch = (out_tuser[1:0] == 2'(dlr_pkg::CHANNELS - 1));

  `DLR_ASSERT_NXT(a_stall_hold, stalled, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")
  `DLR_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "result valid right after reset")
  `DLR_ASSERT_IMP(a_level_range, out_tvalid, out_tdata[6:0] <= dlr_pkg::LEVEL_MAX, "level above 100")
  `DLR_ASSERT_IMP(a_off_dark, out_tvalid && out_tuser[3:2] == dlr_pkg::PH_OFF, out_tdata[6:0] == 7'd0, "nonzero level while off")
  `DLR_ASSERT_IMP(a_last_marks_end, out_tvalid, out_tlast == last_ch, "tlast not on final channel")

endmodule

bind daylight_led_ramp dlr_checker u_dlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
